// File: hw/rtl/shdip_pkg.sv
// Package for the signed hex/decimal integer parser.
// Holds the item and result beat types and the character codes.
// No dependencies.
package shdip_pkg;

    // Character codes recognised by the parser.
    localparam logic [15:0] CHAR_MINUS = 16'h002D;
    localparam logic [15:0] CHAR_X_LOW = 16'h0078;
    localparam logic [15:0] CHAR_ZERO  = 16'h0030;
    localparam logic [15:0] CHAR_NINE  = 16'h0039;
    localparam logic [15:0] CHAR_A_UP  = 16'h0041;
    localparam logic [15:0] CHAR_F_UP  = 16'h0046;
    localparam logic [15:0] CHAR_A_LOW = 16'h0061;
    localparam logic [15:0] CHAR_F_LOW = 16'h0066;

    // Digit limits of the two number forms.
    localparam logic [3:0] DEC_LIMIT = 4'd10;
    localparam logic [3:0] HEX_LIMIT = 4'd8;

    // One input beat.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        begin_parse;
        logic        end_of_buffer;
    } unit_t;

    // One result beat.
    typedef struct packed {
        logic signed [31:0] parsed_value;
        logic [3:0]         consumed_count;
        logic               parse_ok;
    } result_t;

    // Handshake between the parse core and the result register.
    typedef struct packed {
        logic    valid;
        result_t data;
    } core_result_t;

endpackage

// File: hw/rtl/shdip_if.sv
// Channel interfaces for the signed hex/decimal integer parser.
// Does not depend on shdip_pkg; the field widths are written out here.

// Input channel: one text code unit per beat.
interface shdip_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        begin_parse;
    logic        end_of_buffer;

    modport source (output valid, output code_unit, output begin_parse,
                    output end_of_buffer, input ready);
    modport sink   (input valid, input code_unit, input begin_parse,
                    input end_of_buffer, output ready);
endinterface

// Output channel: one parse result per beat.
interface shdip_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] parsed_value;
    logic [3:0]         consumed_count;
    logic               parse_ok;

    modport source (output valid, output parsed_value, output consumed_count,
                    output parse_ok, input ready);
    modport sink   (input valid, input parsed_value, input consumed_count,
                    input parse_ok, output ready);
endinterface

// File: hw/rtl/shdip_in_stage.sv
// Input register of the signed hex/decimal integer parser.
// Depends on shdip_pkg (unit_t).
module shdip_in_stage
    import shdip_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  unit_t in_data,
    input  logic  take,
    output logic  held_valid,
    output unit_t held_data
);

    logic  vld_reg;
    unit_t data_reg;

    // The register refills in the same cycle as the core takes its beat.
    assign in_ready   = !vld_reg || take;
    assign held_valid = vld_reg;
    assign held_data  = data_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

endmodule

// File: hw/rtl/shdip_core.sv
// Parse state and single-step logic of the signed hex/decimal integer parser.
// Depends on shdip_pkg (unit_t, core_result_t, character codes, limits).
module shdip_core
    import shdip_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  unit_t        unit_in,
    output core_result_t res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SIGN,
        PH_ZERO,
        PH_ZEROX,
        PH_HEX,
        PH_DEC
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic [3:0]  taken_reg, taken_next;

    logic [15:0] c;
    logic        is_dec, is_hex, fin, ok;
    logic [3:0]  dval, hval, taken_base;
    logic [31:0] acc_dec, acc_hex, value;

    // Character classification.
    assign c      = unit_in.code_unit;
    assign is_dec = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign is_hex = is_dec || ((c >= CHAR_A_UP) && (c <= CHAR_F_UP))
                    || ((c >= CHAR_A_LOW) && (c <= CHAR_F_LOW));
    assign dval   = c[3:0];
    assign hval   = is_dec ? c[3:0] : c[3:0] + 4'd9;

    // Accumulate one digit: times ten by two shifts and an add, or times sixteen.
    assign acc_dec = (acc_reg << 3) + (acc_reg << 1) + {28'd0, dval};
    assign acc_hex = (acc_reg << 4) + {28'd0, hval};

    // Units already taken before this one.
    assign taken_base = unit_in.begin_parse ? 4'd0 : taken_reg;

    // Next state and result for one unit.
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        taken_next = taken_reg;
        fin        = 1'b0;
        ok         = 1'b0;
        if (unit_in.begin_parse)
        begin
            acc_next   = '0;
            cnt_next   = '0;
            neg_next   = 1'b0;
            taken_next = '0;
        end
        if (unit_in.begin_parse && c == CHAR_MINUS)
        begin
            neg_next   = 1'b1;
            taken_next = 4'd1;
            if (unit_in.end_of_buffer)
            begin
                fin = 1'b1;
            end
            else
            begin
                phase_next = PH_SIGN;
            end
        end
        else if (unit_in.begin_parse || phase_reg == PH_SIGN)
        begin
            // First digit after the optional sign.
            if (!is_dec)
            begin
                fin = 1'b1;
            end
            else
            begin
                acc_next   = {28'd0, dval};
                cnt_next   = 4'd1;
                taken_next = taken_base + 4'd1;
                if (unit_in.end_of_buffer)
                begin
                    fin = 1'b1;
                    ok  = 1'b1;
                end
                else
                begin
                    phase_next = (dval == 4'd0) ? PH_ZERO : PH_DEC;
                end
            end
        end
        else if (phase_reg == PH_ZERO && c == CHAR_X_LOW)
        begin
            // A hex prefix needs a unit after the 'x'.
            if (unit_in.end_of_buffer)
            begin
                fin = 1'b1;
                ok  = 1'b1;
            end
            else
            begin
                taken_next = taken_reg + 4'd1;
                phase_next = PH_ZEROX;
            end
        end
        else if (phase_reg == PH_ZERO || phase_reg == PH_DEC)
        begin
            // Further decimal digits.
            if (!is_dec)
            begin
                fin = 1'b1;
                ok  = 1'b1;
            end
            else
            begin
                acc_next   = acc_dec;
                cnt_next   = cnt_reg + 4'd1;
                taken_next = taken_reg + 4'd1;
                if (unit_in.end_of_buffer || cnt_next >= DEC_LIMIT)
                begin
                    fin = 1'b1;
                    ok  = 1'b1;
                end
                else
                begin
                    phase_next = PH_DEC;
                end
            end
        end
        else if (phase_reg == PH_ZEROX || phase_reg == PH_HEX)
        begin
            // Hex digits; a bad first digit fails the whole parse.
            if (phase_reg == PH_ZEROX)
            begin
                acc_next = '0;
            end
            if (!is_hex)
            begin
                fin = 1'b1;
                ok  = (phase_reg == PH_HEX);
            end
            else
            begin
                acc_next   = (phase_reg == PH_ZEROX) ? {28'd0, hval} : acc_hex;
                cnt_next   = (phase_reg == PH_ZEROX) ? 4'd1 : cnt_reg + 4'd1;
                taken_next = taken_reg + 4'd1;
                if (unit_in.end_of_buffer || cnt_next >= HEX_LIMIT)
                begin
                    fin = 1'b1;
                    ok  = 1'b1;
                end
                else
                begin
                    phase_next = PH_HEX;
                end
            end
        end
        else
        begin
            phase_next = PH_IDLE;
        end
        if (fin)
        begin
            phase_next = PH_IDLE;
        end
    end

    // Result: negate the wrapped magnitude when a sign was seen.
    assign value                   = neg_next ? (32'd0 - acc_next) : acc_next;
    assign res.valid               = fin;
    assign res.data.parsed_value   = ok ? $signed(value) : 32'sd0;
    assign res.data.consumed_count = ok ? taken_next : 4'd0;
    assign res.data.parse_ok       = ok;

    // Parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            neg_reg   <= 1'b0;
            taken_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            neg_reg   <= neg_next;
            taken_reg <= taken_next;
        end
    end

endmodule

// File: hw/rtl/shdip_out_stage.sv
// Result register of the signed hex/decimal integer parser.
// Depends on shdip_pkg (result_t, core_result_t).
module shdip_out_stage
    import shdip_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  core_result_t res,
    output logic         space,
    output logic         out_valid,
    input  logic         out_ready,
    output result_t      out_data
);

    logic    vld_reg;
    result_t data_reg;

    // The register can take a result when empty or being emptied.
    assign space     = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (space)
        begin
            vld_reg <= step && res.valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (space && step && res.valid)
        begin
            data_reg <= res.data;
        end
    end

endmodule

// File: hw/rtl/signed_hex_decimal_int_parser_unit.sv
// Top level of the signed hex/decimal integer parser.
// Depends on shdip_pkg, shdip_if, shdip_in_stage, shdip_core and shdip_out_stage.
//
//  Channel   Role   Beat payload
//  units     sink   code_unit[15:0], begin_parse, end_of_buffer
//  results   source parsed_value[31:0] signed, consumed_count[3:0], parse_ok
//
// One unit per cycle is taken unless a finished result waits on a full result register; the
// unit that ends a parse is registered in the input register, its result in the result register.
// The rate is set by the parse state loop, one short accumulate-and-compare per cycle.
// Reset clears the parse state to idle and empties both registers.
// A unit that ends a parse waits in the input register while the result register is full;
// other units keep flowing.
module signed_hex_decimal_int_parser_unit
    import shdip_pkg::*;
(
    input logic           clk,
    input logic           rst_n,
    shdip_unit_if.sink    units,
    shdip_result_if.source results
);

    unit_t        in_data, held_data;
    result_t      out_data;
    core_result_t res;
    logic         held_valid, space, step;

    assign in_data.code_unit     = units.code_unit;
    assign in_data.begin_parse   = units.begin_parse;
    assign in_data.end_of_buffer = units.end_of_buffer;

    // The core steps unless its result cannot be stored.
    assign step = held_valid && (space || !res.valid);

    shdip_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (units.valid),
        .in_ready   (units.ready),
        .in_data    (in_data),
        .take       (step),
        .held_valid (held_valid),
        .held_data  (held_data)
    );

    shdip_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .unit_in (held_data),
        .res     (res)
    );

    shdip_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .res       (res),
        .space     (space),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_data  (out_data)
    );

    assign results.parsed_value   = out_data.parsed_value;
    assign results.consumed_count = out_data.consumed_count;
    assign results.parse_ok       = out_data.parse_ok;

endmodule
